FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the blit core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/ckb_pkg.sv
// ----------------------------------------------------------------------------
// ckb_pkg
// Types, register codes and reset values for the color-key blit core.
// ----------------------------------------------------------------------------
package ckb_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int POS_W       = 8;
   localparam int PIX_W       = 8;
   localparam int VIEW_W      = 10;
   localparam int COORD_W     = 12;
   localparam int ADDR_W      = 20;
   localparam int COUNT_W     = 16;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEST_X       = 3'd0,
      CSR_DEST_Y       = 3'd1,
      CSR_FRAME_WIDTH  = 3'd2,
      CSR_FRAME_HEIGHT = 3'd3,
      CSR_FLIP         = 3'd4,
      CSR_KEY_COLOR    = 3'd5,
      CSR_VIEW_WIDTH   = 3'd6,
      CSR_VIEW_HEIGHT  = 3'd7
   } csr_index_type;

   // reset values
   localparam logic signed [9:0]  RST_DEST_X       = 10'sd0;
   localparam logic signed [9:0]  RST_DEST_Y       = 10'sd20;
   localparam logic [7:0]         RST_FRAME_WIDTH  = 8'd72;
   localparam logic [7:0]         RST_FRAME_HEIGHT = 8'd71;
   localparam logic               RST_FLIP         = 1'b0;
   localparam logic [7:0]         RST_KEY_COLOR    = 8'd10;
   localparam logic [VIEW_W-1:0]  RST_VIEW_WIDTH   = 10'd224;
   localparam logic [VIEW_W-1:0]  RST_VIEW_HEIGHT  = 10'd136;

   // configuration as seen by the datapath
   typedef struct packed {
      logic signed [9:0]  dest_x;
      logic signed [9:0]  dest_y;
      logic [POS_W-1:0]   frame_width;
      logic [POS_W-1:0]   frame_height;
      logic               flip;
      logic [PIX_W-1:0]   key_color;
      logic [VIEW_W-1:0]  view_width;
      logic [VIEW_W-1:0]  view_height;
   } cfg_type;

   // input-stage beat: pixel and its source position
   typedef struct packed {
      logic [PIX_W-1:0]   pixel;
      logic [POS_W-1:0]   column_pos;
      logic [POS_W-1:0]   row_pos;
      logic               frame_end;
   } stage_type;

   // saturating increment
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      sat_inc = (c == {COUNT_W{1'b1}}) ? c : c + {{(COUNT_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

FILE: sv/color_key_clip_mirror_blit_core.sv
// An accepted pixel is held in the input register, then in the result register.
// Throughput: one pixel per cycle; input register and result register form
// a two-beat pipeline that stalls only when the result side holds off.
// Reset: synchronous, active high; clears position and counters and loads
// the register defaults.
// ----------------------------------------------------------------------------
// color_key_clip_mirror_blit_core
// Color-key transparent blit with viewport clipping and horizontal mirror.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module color_key_clip_mirror_blit_core
   import ckb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // source pixels
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_W-1:0]       req_pixel,
   // results
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_write_enable,
   output logic [ADDR_W-1:0]      rsp_dest_addr,
   output logic [PIX_W-1:0]       rsp_pixel_out,
   output logic                   rsp_clipped,
   output logic                   rsp_transparent,
   output logic                   rsp_rejected,
   output logic                   rsp_frame_last,
   output logic [COUNT_W-1:0]     rsp_copied_count,
   output logic [COUNT_W-1:0]     rsp_transparent_count,
   output logic [COUNT_W-1:0]     rsp_clipped_count
);

   cfg_type    cfg;
   stage_type  stage;
   logic       stage_valid;
   logic       stage_take;
   logic       req_accept;
   logic [3:0] rsp_outcome;
   logic       rsp_payload_zero;

   // pipeline flow control
   assign stage_take = stage_valid && (!rsp_valid || rsp_ready);
   assign req_ready  = !stage_valid || stage_take;
   assign req_accept = req_valid && req_ready;

   ckb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ckb_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_accept  (req_accept),
      .req_pixel   (req_pixel),
      .stage_take  (stage_take),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   ckb_blit u_blit (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .stage                 (stage),
      .stage_take            (stage_take),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_write_enable      (rsp_write_enable),
      .rsp_dest_addr         (rsp_dest_addr),
      .rsp_pixel_out         (rsp_pixel_out),
      .rsp_clipped           (rsp_clipped),
      .rsp_transparent       (rsp_transparent),
      .rsp_rejected          (rsp_rejected),
      .rsp_frame_last        (rsp_frame_last),
      .rsp_copied_count      (rsp_copied_count),
      .rsp_transparent_count (rsp_transparent_count),
      .rsp_clipped_count     (rsp_clipped_count)
   );

   // outcome flags and idle payload seen by the checks below
   assign rsp_outcome      = {rsp_write_enable, rsp_clipped, rsp_transparent, rsp_rejected};
   assign rsp_payload_zero = (rsp_dest_addr == '0) && (rsp_pixel_out == '0);

   // exactly one outcome per result beat
   `ASSERT_IMPLIES(a_one_outcome, clock, reset, rsp_valid, $onehot(rsp_outcome))
   // no address or pixel unless written
   `ASSERT_IMPLIES(a_idle_payload, clock, reset, rsp_valid && !rsp_write_enable, rsp_payload_zero)
   // a clipped pixel is already counted
   `ASSERT_IMPLIES(a_clip_counted, clock, reset, rsp_valid && rsp_clipped, rsp_clipped_count != '0)
   // a pixel in the input register moves on whenever the result side is free
   `ASSERT_NEXT(a_stage_drains, clock, reset, stage_valid && !rsp_valid && !req_valid, rsp_valid)

endmodule

FILE: sv/ckb_csr.sv
// ----------------------------------------------------------------------------
// ckb_csr
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ckb_csr
   import ckb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEST_X:       cfg_in.dest_x       = csr_wdata;
            CSR_DEST_Y:       cfg_in.dest_y       = csr_wdata;
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_wdata[POS_W-1:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_wdata[POS_W-1:0];
            CSR_FLIP:         cfg_in.flip         = csr_wdata[0];
            CSR_KEY_COLOR:    cfg_in.key_color    = csr_wdata[PIX_W-1:0];
            CSR_VIEW_WIDTH:   cfg_in.view_width   = csr_wdata[VIEW_W-1:0];
            CSR_VIEW_HEIGHT:  cfg_in.view_height  = csr_wdata[VIEW_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x       <= RST_DEST_X;
         cfg_ff.dest_y       <= RST_DEST_Y;
         cfg_ff.frame_width  <= RST_FRAME_WIDTH;
         cfg_ff.frame_height <= RST_FRAME_HEIGHT;
         cfg_ff.flip         <= RST_FLIP;
         cfg_ff.key_color    <= RST_KEY_COLOR;
         cfg_ff.view_width   <= RST_VIEW_WIDTH;
         cfg_ff.view_height  <= RST_VIEW_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/ckb_scan.sv
// ----------------------------------------------------------------------------
// ckb_scan
// Input register and source position tracker (column, row, frame end).
// ----------------------------------------------------------------------------
module ckb_scan
   import ckb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_accept,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             stage_take,
   output logic             stage_valid,
   output stage_type        stage
);

   logic             stage_valid_ff, stage_valid_in;
   stage_type        stage_ff, stage_in;
   logic [POS_W-1:0] column_pos_ff, column_pos_in;
   logic [POS_W-1:0] row_pos_ff, row_pos_in;
   logic [POS_W-1:0] last_col;
   logic [POS_W-1:0] last_row;
   logic             row_end;
   logic             frame_end;

   // a size of zero wraps to 255 and acts as 256
   assign last_col  = cfg.frame_width - {{(POS_W-1){1'b0}}, 1'b1};
   assign last_row  = cfg.frame_height - {{(POS_W-1){1'b0}}, 1'b1};
   assign row_end   = column_pos_ff >= last_col;
   assign frame_end = row_end && (row_pos_ff >= last_row);

   // position advance per accepted beat
   always_comb begin
      column_pos_in = column_pos_ff;
      row_pos_in    = row_pos_ff;
      if (req_accept) begin
         if (frame_end) begin
            column_pos_in = '0;
            row_pos_in    = '0;
         end else if (row_end) begin
            column_pos_in = '0;
            row_pos_in    = row_pos_ff + {{(POS_W-1){1'b0}}, 1'b1};
         end else begin
            column_pos_in = column_pos_ff + {{(POS_W-1){1'b0}}, 1'b1};
         end
      end
   end

   // input register
   always_comb begin
      stage_in = stage_ff;
      if (req_accept) begin
         stage_in.pixel      = req_pixel;
         stage_in.column_pos = column_pos_ff;
         stage_in.row_pos    = row_pos_ff;
         stage_in.frame_end  = frame_end;
      end
      stage_valid_in = req_accept ? 1'b1 : (stage_take ? 1'b0 : stage_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         column_pos_ff  <= '0;
         row_pos_ff     <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         column_pos_ff  <= column_pos_in;
         row_pos_ff     <= row_pos_in;
      end
      stage_ff <= stage_in;
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

endmodule

FILE: sv/ckb_blit.sv
// ----------------------------------------------------------------------------
// ckb_blit
// Placement, clip and key test, address generation, frame counters and the
// result register.
// ----------------------------------------------------------------------------
module ckb_blit
   import ckb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  stage_type          stage,
   input  logic               stage_take,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic               rsp_write_enable,
   output logic [ADDR_W-1:0]  rsp_dest_addr,
   output logic [PIX_W-1:0]   rsp_pixel_out,
   output logic               rsp_clipped,
   output logic               rsp_transparent,
   output logic               rsp_rejected,
   output logic               rsp_frame_last,
   output logic [COUNT_W-1:0] rsp_copied_count,
   output logic [COUNT_W-1:0] rsp_transparent_count,
   output logic [COUNT_W-1:0] rsp_clipped_count
);

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      we_ff, we_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [PIX_W-1:0]          pout_ff, pout_in;
   logic                      clip_ff, clip_in;
   logic                      transp_ff, transp_in;
   logic                      rej_ff, rej_in;
   logic                      last_ff, last_in;
   logic [COUNT_W-1:0]        copied_out_ff, copied_out_in;
   logic [COUNT_W-1:0]        transp_out_ff, transp_out_in;
   logic [COUNT_W-1:0]        clip_out_ff, clip_out_in;
   logic [COUNT_W-1:0]        copied_total_ff, copied_total_in;
   logic [COUNT_W-1:0]        transp_total_ff, transp_total_in;
   logic [COUNT_W-1:0]        clip_total_ff, clip_total_in;

   logic [POS_W-1:0]          last_col;
   logic signed [COORD_W-1:0] col_off;
   logic signed [COORD_W-1:0] dx;
   logic signed [COORD_W-1:0] dy;
   logic signed [COORD_W-1:0] vw_s;
   logic signed [COORD_W-1:0] vh_s;
   logic                      view_zero;
   logic                      outside;
   logic                      key_hit;
   logic [ADDR_W-1:0]         row_base;

   // destination coordinates, column mirrored when flip is set
   assign last_col = cfg.frame_width - {{(POS_W-1){1'b0}}, 1'b1};
   assign col_off  = cfg.flip
                   ? $signed({{(COORD_W-POS_W){1'b0}}, last_col})
                     - $signed({{(COORD_W-POS_W){1'b0}}, stage.column_pos})
                   : $signed({{(COORD_W-POS_W){1'b0}}, stage.column_pos});
   assign dx = {{(COORD_W-10){cfg.dest_x[9]}}, cfg.dest_x} + col_off;
   assign dy = {{(COORD_W-10){cfg.dest_y[9]}}, cfg.dest_y}
             + $signed({{(COORD_W-POS_W){1'b0}}, stage.row_pos});

   // viewport tests
   assign vw_s      = $signed({{(COORD_W-VIEW_W){1'b0}}, cfg.view_width});
   assign vh_s      = $signed({{(COORD_W-VIEW_W){1'b0}}, cfg.view_height});
   assign view_zero = (cfg.view_width == '0) || (cfg.view_height == '0);
   assign outside   = dx[COORD_W-1] || (dx >= vw_s) || dy[COORD_W-1] || (dy >= vh_s);
   assign key_hit   = stage.pixel == cfg.key_color;

   // row times width; dy is in range whenever the address is used
   assign row_base = ADDR_W'(dy[VIEW_W-1:0]) * ADDR_W'(cfg.view_width);

   // classification and counter update
   always_comb begin
      we_in           = 1'b0;
      addr_in         = '0;
      pout_in         = '0;
      clip_in         = 1'b0;
      transp_in       = 1'b0;
      rej_in          = 1'b0;
      copied_out_in   = copied_total_ff;
      transp_out_in   = transp_total_ff;
      clip_out_in     = clip_total_ff;
      if (view_zero) begin
         rej_in = 1'b1;
      end else if (outside) begin
         clip_in     = 1'b1;
         clip_out_in = sat_inc(clip_total_ff);
      end else if (key_hit) begin
         transp_in     = 1'b1;
         transp_out_in = sat_inc(transp_total_ff);
      end else begin
         we_in         = 1'b1;
         pout_in       = stage.pixel;
         addr_in       = row_base + ADDR_W'(dx[VIEW_W-1:0]);
         copied_out_in = sat_inc(copied_total_ff);
      end
      last_in = stage.frame_end;
   end

   // running totals clear after the last pixel of the frame
   always_comb begin
      copied_total_in = copied_total_ff;
      transp_total_in = transp_total_ff;
      clip_total_in   = clip_total_ff;
      if (stage_take) begin
         copied_total_in = stage.frame_end ? '0 : copied_out_in;
         transp_total_in = stage.frame_end ? '0 : transp_out_in;
         clip_total_in   = stage.frame_end ? '0 : clip_out_in;
      end
      rsp_valid_in = stage_take ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         copied_total_ff <= '0;
         transp_total_ff <= '0;
         clip_total_ff   <= '0;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         copied_total_ff <= copied_total_in;
         transp_total_ff <= transp_total_in;
         clip_total_ff   <= clip_total_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (stage_take) begin
         we_ff         <= we_in;
         addr_ff       <= addr_in;
         pout_ff       <= pout_in;
         clip_ff       <= clip_in;
         transp_ff     <= transp_in;
         rej_ff        <= rej_in;
         last_ff       <= last_in;
         copied_out_ff <= copied_out_in;
         transp_out_ff <= transp_out_in;
         clip_out_ff   <= clip_out_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_write_enable      = we_ff;
   assign rsp_dest_addr         = addr_ff;
   assign rsp_pixel_out         = pout_ff;
   assign rsp_clipped           = clip_ff;
   assign rsp_transparent       = transp_ff;
   assign rsp_rejected          = rej_ff;
   assign rsp_frame_last        = last_ff;
   assign rsp_copied_count      = copied_out_ff;
   assign rsp_transparent_count = transp_out_ff;
   assign rsp_clipped_count     = clip_out_ff;

endmodule
